### design/sffg_pkg.sv
// Package for the serial frame filter gateway: shared constants, the command
// passed from the front end to the back end, the back-end state type and a helper.
// No dependencies.
package sffg_pkg;

    // Default sizes, handed down from the top level as parameters.
    localparam int DEF_FRAME_DEPTH = 64;
    localparam int DEF_MATCH_BYTES = 8;

    // Width of a frame total (length plus two), large enough for the largest length byte.
    localparam int TOT_W = 9;

    // Framing constants.
    localparam logic [7:0] SYNC_A  = 8'h5A;
    localparam logic [7:0] SYNC_B  = 8'hA5;
    localparam logic [7:0] SUM_OK  = 8'hFF;
    localparam logic [7:0] MIN_LEN = 8'd2;

    // Configuration register indexes and reset values.
    localparam int          CFG_IDX_W          = 2;
    localparam logic [1:0]  CFG_DISCARD_SOURCE = 2'd0;
    localparam logic [1:0]  CFG_MATCH_MESSAGE  = 2'd1;
    localparam logic [1:0]  CFG_REPLACE_MESSAGE = 2'd2;
    localparam logic [7:0]  DISCARD_RST = 8'hA5;
    localparam logic [63:0] MATCH_RST   = 64'hA50606863D008A01;
    localparam logic [63:0] REPLACE_RST = 64'hA50606FFFFFFFF52;

    // Command queue between front and back end.
    localparam int CMDQ_DEPTH = 4;
    localparam int CMDQ_PTR_W = 2;

    // Work orders for the back end.
    typedef enum logic [1:0] {
        OP_BYTE,   // emit one plain byte
        OP_PAIR,   // emit the held sync byte and the length byte
        OP_FWD,    // emit a stored frame in full
        OP_REPL    // emit the replacement message
    } t_cmd_op;

    typedef struct packed {
        t_cmd_op          op;
        logic [7:0]       byte_a;
        logic [7:0]       byte_b;
        logic             flag;    // oversize for a pair, checksum failure for frames
        logic [TOT_W-1:0] total;
    } t_cmd;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PAIR,
        S_REPL,
        S_FRD,
        S_FLD
    } t_back_state;

    // Byte i of an eight-byte message, first byte in the top bits.
    function automatic logic [7:0] msg_byte(input logic [63:0] msg, input logic [2:0] i);
        logic [5:0] sh;
        sh = 6'd56 - {i, 3'b000};
        return 8'(msg >> sh);
    endfunction

endpackage

### design/serial_frame_filter_gateway_unit.sv
// Serial frame filter gateway. A byte outside a frame reaches the ports through the
// command queue and result register. Frame bytes are accepted one per cycle unless
// input stalls (queue full, or a forwarded frame being read out). A complete frame is
// replaced, forwarded or dropped; forwarded bytes take a registered store read (S_FRD)
// and a load (S_FLD), replacement bytes one per cycle while the result slot is free.
// Synchronous reset clears framing, queue, results and registers; the store is kept.
module serial_frame_filter_gateway_unit import sffg_pkg::*; #(
    parameter int FRAME_DEPTH = DEF_FRAME_DEPTH,
    parameter int MATCH_BYTES = DEF_MATCH_BYTES
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 push,
    output logic                 full,
    input  logic [7:0]           i_in_byte,
    output logic                 empty,
    input  logic                 pop,
    output logic [7:0]           o_out_byte,
    output logic                 o_last_of_run,
    output logic                 o_checksum_bad,
    output logic                 o_replaced,
    output logic                 o_oversize,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [63:0]          i_cfg_data
);

    localparam int ADDR_W = $clog2(FRAME_DEPTH);

    logic [7:0]        r_discard_source;
    logic [63:0]       r_match_message;
    logic [63:0]       r_replace_message;

    logic              q_full;
    logic              q_empty;
    logic              q_push;
    logic              q_pop;
    t_cmd              q_in_cmd;
    t_cmd              q_out_cmd;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [7:0]        wr_data;
    logic              fwd_done;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_discard_source  <= DISCARD_RST;
            r_match_message   <= MATCH_RST;
            r_replace_message <= REPLACE_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_DISCARD_SOURCE:  r_discard_source  <= i_cfg_data[7:0];
                CFG_MATCH_MESSAGE:   r_match_message   <= i_cfg_data;
                CFG_REPLACE_MESSAGE: r_replace_message <= i_cfg_data;
                default:             r_discard_source  <= r_discard_source;
            endcase
        end
    end

    // Front end: framing and classification.
    sffg_front #(
        .FRAME_DEPTH (FRAME_DEPTH),
        .MATCH_BYTES (MATCH_BYTES)
    ) u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_push           (push),
        .i_in_byte        (i_in_byte),
        .o_full           (full),
        .i_discard_source (r_discard_source),
        .i_match_message  (r_match_message),
        .i_q_full         (q_full),
        .i_fwd_done       (fwd_done),
        .o_cmd_push       (q_push),
        .o_cmd            (q_in_cmd),
        .o_wr_en          (wr_en),
        .o_wr_addr        (wr_addr),
        .o_wr_data        (wr_data)
    );

    // Command queue between the two halves.
    sffg_cmdq u_cmdq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (q_in_cmd),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_cmd   (q_out_cmd)
    );

    // Back end: emission of results.
    sffg_back #(
        .FRAME_DEPTH (FRAME_DEPTH),
        .MATCH_BYTES (MATCH_BYTES)
    ) u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_q_empty         (q_empty),
        .i_cmd             (q_out_cmd),
        .o_q_pop           (q_pop),
        .i_replace_message (r_replace_message),
        .i_wr_en           (wr_en),
        .i_wr_addr         (wr_addr),
        .i_wr_data         (wr_data),
        .i_pop             (pop),
        .o_empty           (empty),
        .o_out_byte        (o_out_byte),
        .o_last_of_run     (o_last_of_run),
        .o_checksum_bad    (o_checksum_bad),
        .o_replaced        (o_replaced),
        .o_oversize        (o_oversize),
        .o_fwd_done        (fwd_done)
    );

endmodule

### design/sffg_cmdq.sv
// Short command queue that decouples the front end from the back end.
// Depends on sffg_pkg.
module sffg_cmdq import sffg_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_full,
    input  logic i_pop,
    output logic o_empty,
    output t_cmd o_cmd
);

    t_cmd                r_mem [CMDQ_DEPTH];
    logic [CMDQ_PTR_W-1:0] r_wr_ptr;
    logic [CMDQ_PTR_W-1:0] r_rd_ptr;
    logic [CMDQ_PTR_W:0]   r_cnt;
    logic                  do_push;
    logic                  do_pop;

    assign o_full  = (r_cnt == (CMDQ_PTR_W+1)'(CMDQ_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_cmd   = r_mem[r_rd_ptr];
    assign do_push = i_push & ~o_full;
    assign do_pop  = i_pop & ~o_empty;

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    // Pointers and fill level.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

### design/sffg_front.sv
// Front end: accepts received bytes, tracks framing, count and checksum, keeps
// the frame head for matching and issues commands. Depends on sffg_pkg.
module sffg_front import sffg_pkg::*; #(
    parameter int FRAME_DEPTH = DEF_FRAME_DEPTH,
    parameter int MATCH_BYTES = DEF_MATCH_BYTES
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_push,
    input  logic [7:0]                     i_in_byte,
    output logic                           o_full,
    input  logic [7:0]                     i_discard_source,
    input  logic [63:0]                    i_match_message,
    input  logic                           i_q_full,
    input  logic                           i_fwd_done,
    output logic                           o_cmd_push,
    output t_cmd                           o_cmd,
    output logic                           o_wr_en,
    output logic [$clog2(FRAME_DEPTH)-1:0] o_wr_addr,
    output logic [7:0]                     o_wr_data
);

    localparam int ADDR_W = $clog2(FRAME_DEPTH);
    localparam int CNT_W  = $clog2(FRAME_DEPTH + 1);

    logic [CNT_W-1:0] r_count, n_count;
    logic [7:0]       r_sum, n_sum;
    logic [TOT_W-1:0] r_total, n_total;
    logic             r_fwd_busy, n_fwd_busy;
    logic [7:0]       r_head [MATCH_BYTES];
    logic [7:0]       head_n [MATCH_BYTES];

    logic             accept;
    logic             is_sync;
    logic             len_low;
    logic             len_big;
    logic [7:0]       sum_add;
    logic [CNT_W-1:0] count_inc;
    logic             head_eq;
    logic             sum_bad;

    // The front end stalls while the command queue is full or a forwarded frame is still being read out.
    assign o_full  = i_q_full | r_fwd_busy;
    assign accept  = i_push & ~o_full;

    assign is_sync   = (i_in_byte == SYNC_A) || (i_in_byte == SYNC_B);
    assign len_low   = (i_in_byte < MIN_LEN);
    assign len_big   = (({1'b0, i_in_byte} + TOT_W'(2)) > TOT_W'(FRAME_DEPTH));
    assign sum_add   = r_sum + i_in_byte;
    assign count_inc = r_count + CNT_W'(1);
    assign sum_bad   = (sum_add != SUM_OK);

    // Frame head including the byte now arriving, and its comparison.
    always_comb begin
        head_eq = 1'b1;
        for (int k = 0; k < MATCH_BYTES; k++) begin
            head_n[k] = (r_count == CNT_W'(k)) ? i_in_byte : r_head[k];
            if (head_n[k] != msg_byte(i_match_message, 3'(k))) begin
                head_eq = 1'b0;
            end
        end
    end

    // Framing decisions for the accepted byte.
    always_comb begin
        n_count    = r_count;
        n_sum      = r_sum;
        n_total    = r_total;
        n_fwd_busy = r_fwd_busy;
        o_cmd_push = 1'b0;
        o_cmd      = '0;
        o_wr_en    = 1'b0;
        o_wr_addr  = r_count[ADDR_W-1:0];
        o_wr_data  = i_in_byte;

        if (i_fwd_done) begin
            n_fwd_busy = 1'b0;
        end

        if (accept) begin
            if (r_count == '0) begin
                if (is_sync) begin
                    o_wr_en = 1'b1;
                    n_sum   = i_in_byte;
                    n_count = CNT_W'(1);
                end else begin
                    o_cmd_push  = 1'b1;
                    o_cmd.op    = OP_BYTE;
                    o_cmd.byte_a = i_in_byte;
                end
            end else if (r_count == CNT_W'(1)) begin
                if (len_low || len_big) begin
                    // Bad length: the header passes through as plain bytes.
                    o_cmd_push   = 1'b1;
                    o_cmd.op     = OP_PAIR;
                    o_cmd.byte_a = r_head[0];
                    o_cmd.byte_b = i_in_byte;
                    o_cmd.flag   = ~len_low;
                    n_count      = '0;
                    n_sum        = '0;
                end else begin
                    o_wr_en = 1'b1;
                    n_sum   = sum_add;
                    n_count = CNT_W'(2);
                    n_total = {1'b0, i_in_byte} + TOT_W'(2);
                end
            end else begin
                o_wr_en = 1'b1;
                if (TOT_W'(count_inc) < r_total) begin
                    n_sum   = sum_add;
                    n_count = count_inc;
                end else begin
                    // Frame complete: replace, drop or forward.
                    n_count = '0;
                    n_sum   = '0;
                    o_cmd.flag  = sum_bad;
                    o_cmd.total = r_total;
                    if ((r_total >= TOT_W'(MATCH_BYTES)) && head_eq) begin
                        o_cmd_push = 1'b1;
                        o_cmd.op   = OP_REPL;
                    end else if (r_head[0] != i_discard_source) begin
                        o_cmd_push = 1'b1;
                        o_cmd.op   = OP_FWD;
                        n_fwd_busy = 1'b1;
                    end
                end
            end
        end
    end

    // Head bytes are captured alongside the frame store writes.
    always_ff @(posedge i_clk) begin
        if (o_wr_en) begin
            for (int k = 0; k < MATCH_BYTES; k++) begin
                r_head[k] <= head_n[k];
            end
        end
        r_total <= n_total;
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= '0;
            r_sum      <= '0;
            r_fwd_busy <= 1'b0;
        end else begin
            r_count    <= n_count;
            r_sum      <= n_sum;
            r_fwd_busy <= n_fwd_busy;
        end
    end

endmodule

### design/sffg_back.sv
// Back end: carries out queued commands, holds the frame store and drives the
// registered result stage. Depends on sffg_pkg.
module sffg_back import sffg_pkg::*; #(
    parameter int FRAME_DEPTH = DEF_FRAME_DEPTH,
    parameter int MATCH_BYTES = DEF_MATCH_BYTES
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_q_empty,
    input  t_cmd                           i_cmd,
    output logic                           o_q_pop,
    input  logic [63:0]                    i_replace_message,
    input  logic                           i_wr_en,
    input  logic [$clog2(FRAME_DEPTH)-1:0] i_wr_addr,
    input  logic [7:0]                     i_wr_data,
    input  logic                           i_pop,
    output logic                           o_empty,
    output logic [7:0]                     o_out_byte,
    output logic                           o_last_of_run,
    output logic                           o_checksum_bad,
    output logic                           o_replaced,
    output logic                           o_oversize,
    output logic                           o_fwd_done
);

    localparam int ADDR_W = $clog2(FRAME_DEPTH);

    logic [7:0]        r_frame_store [FRAME_DEPTH];
    logic [7:0]        r_rd_data;
    t_back_state       r_state, n_state;
    logic [ADDR_W-1:0] r_idx, n_idx;
    logic              r_out_valid;
    logic [7:0]        r_out_byte;
    logic              r_out_last;
    logic              r_out_bad;
    logic              r_out_rep;
    logic              r_out_ovs;

    logic              slot_free;
    logic              load;
    logic [7:0]        ld_byte;
    logic              ld_last;
    logic              ld_bad;
    logic              ld_rep;
    logic              ld_ovs;
    logic              rd_en;
    logic              fwd_last;
    logic              repl_last;

    assign slot_free = ~r_out_valid | i_pop;
    assign fwd_last  = ((TOT_W'(r_idx) + TOT_W'(1)) == i_cmd.total);
    assign repl_last = (r_idx == ADDR_W'(MATCH_BYTES - 1));

    // Frame store: written by the front end, read one byte at a time here.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_frame_store[i_wr_addr] <= i_wr_data;
        end
        if (rd_en) begin
            r_rd_data <= r_frame_store[r_idx];
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (!i_q_empty && slot_free) begin
                    case (i_cmd.op)
                        OP_PAIR: n_state = S_PAIR;
                        OP_FWD:  n_state = S_FRD;
                        OP_REPL: n_state = S_REPL;
                        default: n_state = S_IDLE;
                    endcase
                end else if (!i_q_empty && (i_cmd.op == OP_FWD || i_cmd.op == OP_REPL)) begin
                    n_state = (i_cmd.op == OP_FWD) ? S_FRD : S_REPL;
                end
            end
            S_PAIR: begin
                if (slot_free) begin
                    n_state = S_IDLE;
                end
            end
            S_REPL: begin
                if (slot_free && repl_last) begin
                    n_state = S_IDLE;
                end
            end
            S_FRD: begin
                n_state = S_FLD;
            end
            S_FLD: begin
                if (slot_free) begin
                    n_state = fwd_last ? S_IDLE : S_FRD;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Outputs of the sequencer: result loads, queue pops, store reads.
    always_comb begin
        load       = 1'b0;
        ld_byte    = i_cmd.byte_a;
        ld_last    = 1'b0;
        ld_bad     = 1'b0;
        ld_rep     = 1'b0;
        ld_ovs     = 1'b0;
        o_q_pop    = 1'b0;
        rd_en      = 1'b0;
        o_fwd_done = 1'b0;
        n_idx      = r_idx;
        case (r_state)
            S_IDLE: begin
                n_idx = '0;
                if (!i_q_empty && slot_free) begin
                    case (i_cmd.op)
                        OP_BYTE: begin
                            load    = 1'b1;
                            ld_last = 1'b1;
                            o_q_pop = 1'b1;
                        end
                        OP_PAIR: begin
                            load   = 1'b1;
                            ld_ovs = i_cmd.flag;
                        end
                        default: begin
                            load = 1'b0;
                        end
                    endcase
                end
            end
            S_PAIR: begin
                if (slot_free) begin
                    load    = 1'b1;
                    ld_byte = i_cmd.byte_b;
                    ld_last = 1'b1;
                    ld_ovs  = i_cmd.flag;
                    o_q_pop = 1'b1;
                end
            end
            S_REPL: begin
                if (slot_free) begin
                    load    = 1'b1;
                    ld_byte = msg_byte(i_replace_message, r_idx[2:0]);
                    ld_last = repl_last;
                    ld_bad  = i_cmd.flag;
                    ld_rep  = 1'b1;
                    o_q_pop = repl_last;
                    n_idx   = r_idx + ADDR_W'(1);
                end
            end
            S_FRD: begin
                rd_en = 1'b1;
            end
            S_FLD: begin
                if (slot_free) begin
                    load       = 1'b1;
                    ld_byte    = r_rd_data;
                    ld_last    = fwd_last;
                    ld_bad     = i_cmd.flag;
                    o_q_pop    = fwd_last;
                    o_fwd_done = fwd_last;
                    n_idx      = r_idx + ADDR_W'(1);
                end
            end
            default: begin
                n_idx = '0;
            end
        endcase
    end

    // Result register payload.
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out_byte <= ld_byte;
            r_out_last <= ld_last;
            r_out_bad  <= ld_bad;
            r_out_rep  <= ld_rep;
            r_out_ovs  <= ld_ovs;
        end
        r_idx <= n_idx;
    end

    // Sequencer state and result valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (load) begin
                r_out_valid <= 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_empty        = ~r_out_valid;
    assign o_out_byte     = r_out_byte;
    assign o_last_of_run  = r_out_last;
    assign o_checksum_bad = r_out_bad;
    assign o_replaced     = r_out_rep;
    assign o_oversize     = r_out_ovs;

endmodule
